@@ hdl/ifte_pkg.sv @@
// Shared types and constants for the image frame transform engine.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ifte_pkg;

    // Field widths of the channels
    localparam int unsigned POS_W      = 6;
    localparam int unsigned DIM_W      = 7;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned GAIN_W     = 12;
    localparam int unsigned MODE_W     = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned PIX_W      = 3 * CHAN_W;

    // Rescale numerator x*w and exposure product c*gain
    localparam int unsigned PROD_W     = POS_W + DIM_W;
    localparam int unsigned EXP_W      = CHAN_W + GAIN_W;
    localparam int unsigned GAIN_SHIFT = 8;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // Frame store size defaults
    localparam int unsigned DEF_MAX_WIDTH  = 64;
    localparam int unsigned DEF_MAX_HEIGHT = 64;

    // Register reset values
    localparam logic [DIM_W-1:0]  RST_DIM  = 7'd64;
    localparam logic [GAIN_W-1:0] RST_GAIN = 12'd256;

    typedef enum logic [MODE_W-1:0] {
        MODE_INVERT    = 3'd0,
        MODE_MIRROR_X  = 3'd1,
        MODE_MIRROR_Y  = 3'd2,
        MODE_ROT_RIGHT = 3'd3,
        MODE_ROT_LEFT  = 3'd4,
        MODE_RESCALE   = 3'd5,
        MODE_EXPOSURE  = 3'd6
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE       = 3'd0,
        CFG_IN_WIDTH   = 3'd1,
        CFG_IN_HEIGHT  = 3'd2,
        CFG_OUT_WIDTH  = 3'd3,
        CFG_OUT_HEIGHT = 3'd4,
        CFG_GAIN       = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_ACCESS,
        ST_RESULT
    } t_ctrl_state;

    typedef struct packed {
        t_mode             mode;
        logic [DIM_W-1:0]  in_width;
        logic [DIM_W-1:0]  in_height;
        logic [DIM_W-1:0]  out_width;
        logic [DIM_W-1:0]  out_height;
        logic [GAIN_W-1:0] gain;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic check_load;
        logic mem_we;
        logic div_start;
        logic div_step;
        logic mem_re;
        logic out_load;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_write;
        logic err;
        logic rescale;
        logic div_done;
    } t_ctrl_sts;

endpackage

@@ hdl/ifte_channels.sv @@
// Valid/ready channel interfaces: pixel requests, results and register writes.
// Depends on ifte_pkg for field widths.
`timescale 1ns / 1ps

interface ifte_in_if;
    import ifte_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;

    modport source (output valid, opcode, pos_x, pos_y, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, opcode, pos_x, pos_y, red_in, green_in, blue_in,
                    output ready);
endinterface

interface ifte_out_if;
    import ifte_pkg::*;

    logic              valid;
    logic              ready;
    logic              status;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;

    modport source (output valid, status, red_out, green_out, blue_out, input ready);
    modport sink   (input valid, status, red_out, green_out, blue_out, output ready);
endinterface

interface ifte_cfg_if;
    import ifte_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/ifte_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ifte_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/ifte_ctrl.sv @@
// Sequencing state machine: intake, check, divide, frame store access, result.
// Depends on ifte_pkg for the state, command and status types.
`timescale 1ns / 1ps

module ifte_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output ifte_pkg::t_ctrl_cmd o_cmd,
    input  ifte_pkg::t_ctrl_sts i_sts
);
    import ifte_pkg::*;

    t_ctrl_state r_state, n_state;
    logic        r_out_valid, n_out_valid;
    logic        out_free;

    // State and result-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.check_load = 1'b1;
                if (i_sts.is_write) begin
                    o_cmd.mem_we = !i_sts.err;
                    n_state      = ST_RESULT;
                end else if (i_sts.err) begin
                    n_state = ST_RESULT;
                end else if (i_sts.rescale) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIVIDE;
                end else begin
                    n_state = ST_ACCESS;
                end
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                o_cmd.mem_re = 1'b1;
                n_state      = ST_RESULT;
            end
            ST_RESULT: begin
                // wait for the output register to drain
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.out_load || (r_out_valid && !i_out_ready);
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ hdl/ifte_datapath.sv @@
// Datapath: item registers, bounds check, rescale dividers, address generation,
// frame store, pixel transform and result register.
// Depends on ifte_pkg and ifte_ram.
`timescale 1ns / 1ps

module ifte_datapath #(
    parameter int unsigned MAX_WIDTH  = ifte_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = ifte_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        i_clk,
    input  ifte_pkg::t_ctrl_cmd         i_cmd,
    output ifte_pkg::t_ctrl_sts         o_sts,
    input  ifte_pkg::t_cfg              i_cfg,
    input  logic                        i_opcode,
    input  logic [ifte_pkg::POS_W-1:0]  i_pos_x,
    input  logic [ifte_pkg::POS_W-1:0]  i_pos_y,
    input  logic [ifte_pkg::CHAN_W-1:0] i_red_in,
    input  logic [ifte_pkg::CHAN_W-1:0] i_green_in,
    input  logic [ifte_pkg::CHAN_W-1:0] i_blue_in,
    output logic                        o_status,
    output logic [ifte_pkg::CHAN_W-1:0] o_red_out,
    output logic [ifte_pkg::CHAN_W-1:0] o_green_out,
    output logic [ifte_pkg::CHAN_W-1:0] o_blue_out
);
    import ifte_pkg::*;

    localparam int unsigned DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW      = $clog2(DEPTH);
    localparam int unsigned DIM_MAX = (1 << DIM_W) - 1;
    localparam int unsigned WCAP    = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
    localparam int unsigned HCAP    = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
    localparam int unsigned LOW_W   = PROD_W - POS_W;
    localparam int unsigned CNT_W   = $clog2(DIM_W);
    localparam int unsigned SH_W    = EXP_W - GAIN_SHIFT;

    // Captured item
    t_opcode           r_opcode;
    logic [POS_W-1:0]  r_pos_x;
    logic [POS_W-1:0]  r_pos_y;
    logic [PIX_W-1:0]  r_rgb;
    logic              r_err;

    // Effective sizes and bounds
    logic [DIM_W-1:0]  w, h, ow, oh;
    logic [DIM_W-1:0]  lim_x, lim_y;
    logic [DIM_W-1:0]  x_ext, y_ext;
    logic              mode_bad;
    logic              err_write, err_read, err_now;

    // Rescale dividers, lane 0 for x and lane 1 for y
    logic [PROD_W-1:0] div_prod [2];
    logic [DIM_W-1:0]  div_d    [2];
    logic [DIM_W:0]    div_t    [2];
    logic              div_ge   [2];
    logic [DIM_W-1:0]  r_rem    [2];
    logic [LOW_W-1:0]  r_low    [2];
    logic [DIM_W-1:0]  r_q      [2];
    logic [CNT_W-1:0]  r_div_cnt;

    // Addressing and frame store
    logic [DIM_W-1:0]  src_x, src_y;
    logic [AW-1:0]     wr_addr, rd_addr, mem_addr;
    logic [PIX_W-1:0]  mem_rdata;

    // Pixel transform
    logic [CHAN_W-1:0] ch_raw  [3];
    logic [CHAN_W-1:0] ch_res  [3];
    logic [EXP_W-1:0]  exp_prod[3];
    logic [SH_W-1:0]   exp_sh  [3];
    logic              r_status;
    logic [CHAN_W-1:0] r_chan  [3];

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_opcode <= t_opcode'(i_opcode);
            r_pos_x  <= i_pos_x;
            r_pos_y  <= i_pos_y;
            r_rgb    <= {i_red_in, i_green_in, i_blue_in};
        end
        if (i_cmd.check_load) begin
            r_err <= err_now;
        end
    end

    // Source sizes saturated to the store, zero counts as one
    always_comb begin
        w  = (i_cfg.in_width == '0) ? DIM_W'(1) :
             (i_cfg.in_width > DIM_W'(WCAP)) ? DIM_W'(WCAP) : i_cfg.in_width;
        h  = (i_cfg.in_height == '0) ? DIM_W'(1) :
             (i_cfg.in_height > DIM_W'(HCAP)) ? DIM_W'(HCAP) : i_cfg.in_height;
        ow = (i_cfg.out_width == '0) ? DIM_W'(1) : i_cfg.out_width;
        oh = (i_cfg.out_height == '0) ? DIM_W'(1) : i_cfg.out_height;
    end

    // Output frame size by mode
    always_comb begin
        lim_x    = w;
        lim_y    = h;
        mode_bad = 1'b0;
        case (i_cfg.mode)
            MODE_INVERT, MODE_MIRROR_X, MODE_MIRROR_Y, MODE_EXPOSURE: begin
                lim_x = w;
                lim_y = h;
            end
            MODE_ROT_RIGHT, MODE_ROT_LEFT: begin
                lim_x = h;
                lim_y = w;
            end
            MODE_RESCALE: begin
                lim_x = ow;
                lim_y = oh;
            end
            default: begin
                mode_bad = 1'b1;
            end
        endcase
    end

    assign x_ext     = DIM_W'(r_pos_x);
    assign y_ext     = DIM_W'(r_pos_y);
    assign err_write = (x_ext >= w) || (y_ext >= h);
    assign err_read  = mode_bad || (x_ext >= lim_x) || (y_ext >= lim_y);
    assign err_now   = (r_opcode == OP_WRITE) ? err_write : err_read;

    assign o_sts.is_write = (r_opcode == OP_WRITE);
    assign o_sts.err      = err_now;
    assign o_sts.rescale  = (i_cfg.mode == MODE_RESCALE);
    assign o_sts.div_done = (r_div_cnt == CNT_W'(DIM_W - 1));

    // Restoring division, one quotient bit per step; quotient fits DIM_W bits
    assign div_prod[0] = PROD_W'(r_pos_x) * PROD_W'(w);
    assign div_prod[1] = PROD_W'(r_pos_y) * PROD_W'(h);
    assign div_d[0]    = ow;
    assign div_d[1]    = oh;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            div_t[l]  = {r_rem[l], r_low[l][LOW_W-1]};
            div_ge[l] = (div_t[l] >= {1'b0, div_d[l]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + CNT_W'(1);
        end
        for (int l = 0; l < 2; l++) begin
            if (i_cmd.div_start) begin
                r_rem[l] <= DIM_W'(div_prod[l][PROD_W-1 -: POS_W]);
                r_low[l] <= div_prod[l][LOW_W-1:0];
            end else if (i_cmd.div_step) begin
                r_rem[l] <= div_ge[l] ? DIM_W'(div_t[l] - {1'b0, div_d[l]})
                                      : div_t[l][DIM_W-1:0];
                r_low[l] <= {r_low[l][LOW_W-2:0], 1'b0};
                r_q[l]   <= {r_q[l][DIM_W-2:0], div_ge[l]};
            end
        end
    end

    // Source coordinate of the requested output pixel
    always_comb begin
        src_x = x_ext;
        src_y = y_ext;
        case (i_cfg.mode)
            MODE_MIRROR_X: begin
                src_x = w - DIM_W'(1) - x_ext;
            end
            MODE_MIRROR_Y: begin
                src_y = h - DIM_W'(1) - y_ext;
            end
            MODE_ROT_RIGHT: begin
                src_x = y_ext;
                src_y = h - DIM_W'(1) - x_ext;
            end
            MODE_ROT_LEFT: begin
                src_x = w - DIM_W'(1) - y_ext;
                src_y = x_ext;
            end
            MODE_RESCALE: begin
                src_x = r_q[0];
                src_y = r_q[1];
            end
            default: begin
                src_x = x_ext;
                src_y = y_ext;
            end
        endcase
    end

    // Row-major store address
    assign wr_addr  = AW'(r_pos_y) * AW'(MAX_WIDTH) + AW'(r_pos_x);
    assign rd_addr  = AW'(src_y) * AW'(MAX_WIDTH) + AW'(src_x);
    assign mem_addr = i_cmd.mem_we ? wr_addr : rd_addr;

    ifte_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_we),
        .i_re    (i_cmd.mem_re),
        .i_addr  (mem_addr),
        .i_wdata (r_rgb),
        .o_rdata (mem_rdata)
    );

    // Per-channel transform; index 2 red, 1 green, 0 blue
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ch_raw[c]   = mem_rdata[c*CHAN_W +: CHAN_W];
            exp_prod[c] = EXP_W'(ch_raw[c]) * EXP_W'(i_cfg.gain);
            exp_sh[c]   = exp_prod[c][EXP_W-1:GAIN_SHIFT];
            case (i_cfg.mode)
                MODE_INVERT: begin
                    ch_res[c] = CHAN_MAX - ch_raw[c];
                end
                MODE_EXPOSURE: begin
                    ch_res[c] = (exp_sh[c] > SH_W'(CHAN_MAX)) ? CHAN_MAX
                                                              : exp_sh[c][CHAN_W-1:0];
                end
                default: begin
                    ch_res[c] = ch_raw[c];
                end
            endcase
        end
    end

    // Result register; channels are zero on writes and errors
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status <= r_err;
            for (int c = 0; c < 3; c++) begin
                r_chan[c] <= (r_err || (r_opcode == OP_WRITE)) ? '0 : ch_res[c];
            end
        end
    end

    assign o_status    = r_status;
    assign o_red_out   = r_chan[2];
    assign o_green_out = r_chan[1];
    assign o_blue_out  = r_chan[0];

endmodule

@@ hdl/image_frame_transform_engine_core.sv @@
// Top level of the image frame transform engine: register file, controller, datapath.
// Depends on ifte_pkg, ifte_channels, ifte_ctrl and ifte_datapath.
//
// Usage:
//   i_req carries one transaction per pixel: opcode 0 stores (red,green,blue) at
//   (pos_x,pos_y) of the source frame, opcode 1 asks for output pixel (pos_x,pos_y)
//   under the current mode. Every transaction gives exactly one result on o_rsp:
//   status 0 is ok, status 1 flags a coordinate outside the frame or mode 7.
//   i_cfg writes the mode, sizes and gain registers; it is always ready. The user
//   must write it only while no transaction is in flight; the block does not enforce it.
// Sequence:
//   A read passes the check and frame store access states before the result register
//   loads; a rescale read runs seven divider steps first, one quotient bit per cycle;
//   writes and rejected transactions load it straight after the check. Intake reopens
//   the cycle after the result is loaded, so a transaction runs to its end before the
//   next is taken, set by the sequencer and the single frame store port.
// Reset:
//   Control state clears, registers return to mode 0, sizes 64, gain 256. The
//   frame store is not cleared; reading a pixel never written gives any value.
// Stall:
//   A result waits in the output register; the next transaction is accepted and
//   runs until its own result step, where it holds until o_rsp drains.
`timescale 1ns / 1ps

module image_frame_transform_engine_core #(
    parameter int unsigned MAX_WIDTH  = ifte_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = ifte_pkg::DEF_MAX_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ifte_in_if.sink           i_req,
    ifte_out_if.source        o_rsp,
    ifte_cfg_if.sink          i_cfg
);
    import ifte_pkg::*;

    t_cfg      r_cfg;
    t_ctrl_cmd ctrl_cmd;
    t_ctrl_sts dp_sts;
    logic      in_ready;
    logic      out_valid;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= MODE_INVERT;
            r_cfg.in_width   <= RST_DIM;
            r_cfg.in_height  <= RST_DIM;
            r_cfg.out_width  <= RST_DIM;
            r_cfg.out_height <= RST_DIM;
            r_cfg.gain       <= RST_GAIN;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_MODE:       r_cfg.mode       <= t_mode'(i_cfg.data[MODE_W-1:0]);
                CFG_IN_WIDTH:   r_cfg.in_width   <= i_cfg.data[DIM_W-1:0];
                CFG_IN_HEIGHT:  r_cfg.in_height  <= i_cfg.data[DIM_W-1:0];
                CFG_OUT_WIDTH:  r_cfg.out_width  <= i_cfg.data[DIM_W-1:0];
                CFG_OUT_HEIGHT: r_cfg.out_height <= i_cfg.data[DIM_W-1:0];
                CFG_GAIN:       r_cfg.gain       <= i_cfg.data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ifte_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .o_cmd       (ctrl_cmd),
        .i_sts       (dp_sts)
    );

    ifte_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_cmd       (ctrl_cmd),
        .o_sts       (dp_sts),
        .i_cfg       (r_cfg),
        .i_opcode    (i_req.opcode),
        .i_pos_x     (i_req.pos_x),
        .i_pos_y     (i_req.pos_y),
        .i_red_in    (i_req.red_in),
        .i_green_in  (i_req.green_in),
        .i_blue_in   (i_req.blue_in),
        .o_status    (o_rsp.status),
        .o_red_out   (o_rsp.red_out),
        .o_green_out (o_rsp.green_out),
        .o_blue_out  (o_rsp.blue_out)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

    // Only in-frame writes reach the frame store
    a_write_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.mem_we |-> (dp_sts.is_write && !dp_sts.err))
        else $error("frame store written for a rejected or read transaction");

    // An accepted transaction blocks intake until its result is loaded
    a_intake_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("new transaction accepted while one is in flight");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.out_load |-> (!o_rsp.valid || o_rsp.ready))
        else $error("result register loaded while holding an untaken result");

    // Dividers start only for valid rescale reads
    a_div_rescale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.div_start |-> (dp_sts.rescale && !dp_sts.is_write && !dp_sts.err))
        else $error("divider started outside a valid rescale read");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for image_frame_transform_engine_core: pixel writes, transformed reads.
// Depends on ifte_pkg and the ifte_in_if, ifte_out_if and ifte_cfg_if channel interfaces.
`timescale 1ns / 1ps

module tb;
    import ifte_pkg::*;

    localparam int unsigned FRAME_W      = DEF_MAX_WIDTH;
    localparam int unsigned FRAME_H      = DEF_MAX_HEIGHT;
    localparam int unsigned MAX_IDLE     = 12;
    localparam int unsigned SETTLE       = 16;
    localparam int unsigned DRAIN_LIMIT  = 5000;
    localparam int unsigned NUM_PHASES   = 20;
    localparam int unsigned PHASE_ITEMS  = 48;
    localparam longint unsigned TIMEOUT_NS = 64'd5_000_000;

    // Mode code with no transform behind it
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic              status;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel_result;

    logic i_clk;
    logic i_rst_n;

    ifte_in_if  req_if ();
    ifte_out_if rsp_if ();
    ifte_cfg_if cfg_if ();

    image_frame_transform_engine_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // Shadow copy of the frame store and registers
    logic [PIX_W-1:0]  shadow_frame  [FRAME_W*FRAME_H];
    bit                pixel_written [FRAME_W*FRAME_H];
    logic [MODE_W-1:0] cfg_mode;
    logic [DIM_W-1:0]  cfg_in_width;
    logic [DIM_W-1:0]  cfg_in_height;
    logic [DIM_W-1:0]  cfg_out_width;
    logic [DIM_W-1:0]  cfg_out_height;
    logic [GAIN_W-1:0] cfg_gain;

    t_pixel_result expected_pixels [$];
    int unsigned   fail_count;

    bit          req_gaps_on;
    bit          rsp_stalls_on;
    int unsigned rsp_hold_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
        if (v == 0) return 1;
        return (v > lim) ? lim : v;
    endfunction

    // Size of the output frame under the current mode
    function automatic void output_extent(output int unsigned lim_x, output int unsigned lim_y);
        int unsigned w;
        int unsigned h;
        w = clamp_dim(cfg_in_width, FRAME_W);
        h = clamp_dim(cfg_in_height, FRAME_H);
        lim_x = w;
        lim_y = h;
        case (cfg_mode)
            MODE_ROT_RIGHT, MODE_ROT_LEFT: begin
                lim_x = h;
                lim_y = w;
            end
            MODE_RESCALE: begin
                lim_x = (cfg_out_width == 0) ? 1 : cfg_out_width;
                lim_y = (cfg_out_height == 0) ? 1 : cfg_out_height;
            end
            default: ;
        endcase
    endfunction

    // Source pixel behind output (x,y); returns 0 when the read is rejected
    function automatic bit output_to_source(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                            output int unsigned sx, output int unsigned sy);
        int unsigned w;
        int unsigned h;
        int unsigned lim_x;
        int unsigned lim_y;
        w  = clamp_dim(cfg_in_width, FRAME_W);
        h  = clamp_dim(cfg_in_height, FRAME_H);
        sx = x;
        sy = y;
        output_extent(lim_x, lim_y);
        if (cfg_mode == MODE_UNUSED || x >= lim_x || y >= lim_y) return 0;
        case (cfg_mode)
            MODE_MIRROR_X:  sx = w - 1 - x;
            MODE_MIRROR_Y:  sy = h - 1 - y;
            MODE_ROT_RIGHT: begin
                sx = y;
                sy = h - 1 - x;
            end
            MODE_ROT_LEFT: begin
                sx = w - 1 - y;
                sy = x;
            end
            MODE_RESCALE: begin
                sx = (x * w) / lim_x;
                sy = (y * h) / lim_y;
            end
            default: ;
        endcase
        return 1;
    endfunction

    function automatic logic [CHAN_W-1:0] expose_chan(input logic [CHAN_W-1:0] c);
        int unsigned prod;
        prod = (int'(c) * int'(cfg_gain)) >> GAIN_SHIFT;
        return (prod > CHAN_MAX) ? CHAN_MAX : prod[CHAN_W-1:0];
    endfunction

    // Expected result of one transaction; a write updates the shadow frame
    function automatic t_pixel_result predict_pixel(input t_opcode op,
                                                    input logic [POS_W-1:0] x,
                                                    input logic [POS_W-1:0] y,
                                                    input logic [PIX_W-1:0] rgb);
        t_pixel_result res;
        int unsigned   sx;
        int unsigned   sy;
        logic [PIX_W-1:0] px;
        res = '0;
        if (op == OP_WRITE) begin
            if (x >= clamp_dim(cfg_in_width, FRAME_W) || y >= clamp_dim(cfg_in_height, FRAME_H))
                res.status = STATUS_ERR;
            else begin
                shadow_frame[y*FRAME_W + x]  = rgb;
                pixel_written[y*FRAME_W + x] = 1'b1;
            end
            return res;
        end
        if (!output_to_source(x, y, sx, sy)) begin
            res.status = STATUS_ERR;
            return res;
        end
        px = shadow_frame[sy*FRAME_W + sx];
        res.status = STATUS_OK;
        res.red    = px[3*CHAN_W-1:2*CHAN_W];
        res.green  = px[2*CHAN_W-1:CHAN_W];
        res.blue   = px[CHAN_W-1:0];
        if (cfg_mode == MODE_INVERT) begin
            res.red   = CHAN_MAX - res.red;
            res.green = CHAN_MAX - res.green;
            res.blue  = CHAN_MAX - res.blue;
        end else if (cfg_mode == MODE_EXPOSURE) begin
            res.red   = expose_chan(res.red);
            res.green = expose_chan(res.green);
            res.blue  = expose_chan(res.blue);
        end
        return res;
    endfunction

    // Channel values lean on the extremes
    function automatic logic [CHAN_W-1:0] random_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CHAN_MAX;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        return {random_chan(), random_chan(), random_chan()};
    endfunction

    function automatic int unsigned pick_dim();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2:       return FRAME_W;
            3:       return 127;
            4:       return $urandom_range(65, 127);
            5, 6:    return $urandom_range(1, 64);
            default: return $urandom_range(2, 12);
        endcase
    endfunction

    function automatic int unsigned pick_gain();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 4095;
            2:       return 256;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    // Send one transaction and queue its expected result on acceptance
    task automatic send_pixel(input t_opcode op, input logic [POS_W-1:0] x,
                              input logic [POS_W-1:0] y, input logic [PIX_W-1:0] rgb);
        int unsigned gap;
        gap = req_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.opcode   = op;
        req_if.pos_x    = x;
        req_if.pos_y    = y;
        req_if.red_in   = rgb[3*CHAN_W-1:2*CHAN_W];
        req_if.green_in = rgb[2*CHAN_W-1:CHAN_W];
        req_if.blue_in  = rgb[CHAN_W-1:0];
        req_if.valid    = 1'b1;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        expected_pixels.push_back(predict_pixel(op, x, y, rgb));
    endtask

    // Read an output pixel; the source pixel is stored first if never written
    task automatic read_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        int unsigned sx;
        int unsigned sy;
        if (output_to_source(x, y, sx, sy) && !pixel_written[sy*FRAME_W + sx])
            send_pixel(OP_WRITE, sx[POS_W-1:0], sy[POS_W-1:0], random_pixel());
        send_pixel(OP_READ, x, y, random_pixel());
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_results_drained();
        int unsigned waited;
        waited = 0;
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_pixels.size() != 0) begin
            $error("results missing: %0d still expected", expected_pixels.size());
            fail_count++;
        end
    endtask

    // Register write, only with the engine idle
    task automatic write_register(input t_cfg_idx idx, input int unsigned value);
        wait_results_drained();
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.index = idx;
        cfg_if.data  = value[CFG_DATA_W-1:0];
        cfg_if.valid = 1'b1;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_MODE:       cfg_mode       = value[MODE_W-1:0];
            CFG_IN_WIDTH:   cfg_in_width   = value[DIM_W-1:0];
            CFG_IN_HEIGHT:  cfg_in_height  = value[DIM_W-1:0];
            CFG_OUT_WIDTH:  cfg_out_width  = value[DIM_W-1:0];
            CFG_OUT_HEIGHT: cfg_out_height = value[DIM_W-1:0];
            CFG_GAIN:       cfg_gain       = value[GAIN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // One transaction of random traffic: mostly in-frame writes and valid reads
    task automatic send_random_item();
        int unsigned pick;
        int unsigned lim_x;
        int unsigned lim_y;
        pick = $urandom_range(0, 99);
        output_extent(lim_x, lim_y);
        if (pick < 40)
            send_pixel(OP_WRITE,
                       POS_W'($urandom_range(0, clamp_dim(cfg_in_width, FRAME_W) - 1)),
                       POS_W'($urandom_range(0, clamp_dim(cfg_in_height, FRAME_H) - 1)),
                       random_pixel());
        else if (pick < 85)
            read_pixel(POS_W'($urandom_range(0, lim_x - 1)),
                       POS_W'($urandom_range(0, lim_y - 1)));
        else if (pick < 93)
            send_pixel(OP_WRITE, POS_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)),
                       random_pixel());
        else
            read_pixel(POS_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)));
    endtask

    // Corners, every mode, saturation, size clamping and rejected coordinates
    task automatic test_directed_cases();
        req_gaps_on   = 1'b0;
        rsp_stalls_on = 1'b0;
        send_pixel(OP_WRITE, 0, 0, 24'h000000);
        send_pixel(OP_WRITE, 63, 63, 24'hFFFFFF);
        send_pixel(OP_WRITE, 63, 0, 24'h123456);
        send_pixel(OP_WRITE, 0, 63, 24'h807F01);
        read_pixel(0, 0);
        read_pixel(63, 63);
        write_register(CFG_MODE, MODE_MIRROR_X);
        read_pixel(0, 0);
        read_pixel(63, 63);
        write_register(CFG_MODE, MODE_MIRROR_Y);
        read_pixel(0, 0);
        write_register(CFG_MODE, MODE_ROT_RIGHT);
        read_pixel(0, 0);
        read_pixel(63, 63);
        write_register(CFG_MODE, MODE_ROT_LEFT);
        read_pixel(0, 0);
        // exposure: full gain saturates, zero gain blanks
        write_register(CFG_MODE, MODE_EXPOSURE);
        write_register(CFG_GAIN, 4095);
        read_pixel(63, 63);
        read_pixel(0, 63);
        write_register(CFG_GAIN, 0);
        read_pixel(63, 63);
        write_register(CFG_MODE, MODE_UNUSED);
        read_pixel(0, 0);
        // rescale with zero and oversized dimensions
        write_register(CFG_MODE, MODE_RESCALE);
        write_register(CFG_IN_WIDTH, 0);
        write_register(CFG_IN_HEIGHT, 100);
        write_register(CFG_OUT_WIDTH, 0);
        write_register(CFG_OUT_HEIGHT, 64);
        read_pixel(0, 63);
        read_pixel(1, 0);
        // small frame: write and read outside it are rejected
        write_register(CFG_MODE, MODE_INVERT);
        write_register(CFG_IN_WIDTH, 2);
        write_register(CFG_IN_HEIGHT, 2);
        send_pixel(OP_WRITE, 5, 5, 24'hA5A5A5);
        read_pixel(2, 0);
        read_pixel(1, 1);
    endtask

    // Random traffic over a series of register settings
    task automatic test_random_traffic();
        int unsigned dim;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            write_register(CFG_MODE, (phase < 8) ? phase : $urandom_range(0, 7));
            if (phase == 0) begin
                dim = FRAME_W;
                write_register(CFG_GAIN, 4095);
            end else if (phase == 1) begin
                dim = 1;
                write_register(CFG_GAIN, 0);
            end else
                write_register(CFG_GAIN, pick_gain());
            write_register(CFG_IN_WIDTH, (phase < 2) ? dim : pick_dim());
            write_register(CFG_IN_HEIGHT, (phase < 2) ? dim : pick_dim());
            write_register(CFG_OUT_WIDTH, (phase < 2) ? dim : pick_dim());
            write_register(CFG_OUT_HEIGHT, (phase < 2) ? dim : pick_dim());
            req_gaps_on   = (phase % 4 != 3);
            rsp_stalls_on = (phase % 5 != 4);
            repeat (PHASE_ITEMS) send_random_item();
        end
    endtask

    // Long output stall while the sender keeps offering transactions
    task automatic test_output_backpressure();
        write_register(CFG_MODE, MODE_RESCALE);
        write_register(CFG_IN_WIDTH, 8);
        write_register(CFG_IN_HEIGHT, 8);
        write_register(CFG_OUT_WIDTH, 5);
        write_register(CFG_OUT_HEIGHT, 13);
        req_gaps_on     = 1'b0;
        rsp_stalls_on   = 1'b1;
        rsp_hold_cycles = 80;
        repeat (16) send_random_item();
        wait_results_drained();
    endtask

    // Sender stops until all results are back, then resumes
    task automatic test_sender_pause();
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
        repeat (10) send_random_item();
        wait_results_drained();
        repeat (10) send_random_item();
    endtask

    // Result checker
    always @(posedge i_clk) begin : check_results
        t_pixel_result oldest;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_pixels.size() == 0) begin
                $error("result with no transaction outstanding");
                fail_count++;
            end else begin
                oldest = expected_pixels.pop_front();
                if (rsp_if.status !== oldest.status) begin
                    $error("status: expected %0d, got %0d", oldest.status, rsp_if.status);
                    fail_count++;
                end
                if (rsp_if.red_out !== oldest.red) begin
                    $error("red_out: expected %0d, got %0d", oldest.red, rsp_if.red_out);
                    fail_count++;
                end
                if (rsp_if.green_out !== oldest.green) begin
                    $error("green_out: expected %0d, got %0d", oldest.green, rsp_if.green_out);
                    fail_count++;
                end
                if (rsp_if.blue_out !== oldest.blue) begin
                    $error("blue_out: expected %0d, got %0d", oldest.blue, rsp_if.blue_out);
                    fail_count++;
                end
            end
        end
    end

    // Output ready: random stalls per result, plus a long hold on request
    initial begin : drive_rsp_ready
        int unsigned gap;
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            gap = rsp_stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (rsp_hold_cycles > 0) begin
                gap = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end
            if (gap > 0) begin
                rsp_if.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            rsp_if.ready = 1'b1;
            @(posedge i_clk);
            while (!rsp_if.valid) @(posedge i_clk);
        end
    end

    // Main sequence
    initial begin
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.opcode   = OP_WRITE;
        req_if.pos_x    = '0;
        req_if.pos_y    = '0;
        req_if.red_in   = '0;
        req_if.green_in = '0;
        req_if.blue_in  = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = CFG_MODE;
        cfg_if.data     = '0;
        cfg_mode        = MODE_INVERT;
        cfg_in_width    = RST_DIM;
        cfg_in_height   = RST_DIM;
        cfg_out_width   = RST_DIM;
        cfg_out_height  = RST_DIM;
        cfg_gain        = RST_GAIN;
        fail_count      = 0;
        req_gaps_on     = 1'b0;
        rsp_stalls_on   = 1'b0;
        rsp_hold_cycles = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();

        wait_results_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (expected_pixels.size() != 0) begin
            $error("%0d results never arrived", expected_pixels.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
